@@ design/tcphs_pkg.sv @@
// Shared types and constants for the TCP handshake tracker.
package tcphs_pkg;

    localparam logic [7:0] FlagSyn = 8'h02;
    localparam logic [7:0] FlagAck = 8'h10;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  tcp_flags;
    } t_in_word;

    typedef struct packed {
        logic        syn_event;
        logic        synack_event;
        logic        ack_event;
        logic        connect_event;
        logic        is_connected;
        logic [31:0] client_addr_out;
    } t_out_word;

    // classified segment as it waits in the queue
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] seq_p1;
        logic [31:0] ack_number;
        logic        syn_only;
        logic        synack;
        logic        ack_set;
    } t_cls_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ design/tcphs_front.sv @@
// Front stage: accept a segment header, decode its flags and precompute seq + 1.
module tcphs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tcphs_pkg::t_in_word  i_in_word,
    output logic                 o_in_stall,
    input  tcphs_pkg::t_q_stat   i_q_stat,
    output logic                 o_push,
    output tcphs_pkg::t_cls_word o_cls
);
    import tcphs_pkg::*;

    logic      r_fv;
    logic      n_fv;
    t_cls_word r_cls;
    t_cls_word n_cls;
    logic      take;
    logic      syn;
    logic      ackf;

    assign o_push     = r_fv && !i_q_stat.full;
    assign take       = !r_fv || o_push;
    assign o_in_stall = !take;
    assign o_cls      = r_cls;

    assign syn  = (i_in_word.tcp_flags & FlagSyn) != 8'd0;
    assign ackf = (i_in_word.tcp_flags & FlagAck) != 8'd0;

    always_comb begin
        n_fv = take ? i_in_valid : r_fv;
        n_cls.src_addr   = i_in_word.src_addr;
        n_cls.dst_addr   = i_in_word.dst_addr;
        n_cls.src_port   = i_in_word.src_port;
        n_cls.dst_port   = i_in_word.dst_port;
        n_cls.seq_number = i_in_word.seq_number;
        n_cls.seq_p1     = i_in_word.seq_number + 32'd1;
        n_cls.ack_number = i_in_word.ack_number;
        n_cls.syn_only   = syn && !ackf;
        n_cls.synack     = syn && ackf;
        n_cls.ack_set    = ackf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

@@ design/tcphs_queue.sv @@
// Short queue of classified words between the front and back stages.
module tcphs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcphs_pkg::t_cls_word i_item,
    input  logic                 i_pop,
    output tcphs_pkg::t_cls_word o_item,
    output tcphs_pkg::t_q_stat   o_stat
);
    import tcphs_pkg::*;

    t_cls_word        r_mem [QDepth];
    logic [QAw-1:0]   r_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr;
    logic [QCw-1:0]   r_cnt;
    logic [QCw-1:0]   n_cnt;

    assign o_stat.full  = r_cnt == QCw'(QDepth);
    assign o_stat.empty = r_cnt == '0;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + QCw'(1);
            2'b01:   n_cnt = r_cnt - QCw'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAw'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ design/tcphs_back.sv @@
// Back stage: apply one word to the connection state and register the result.
module tcphs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcphs_pkg::t_q_stat   i_q_stat,
    input  tcphs_pkg::t_cls_word i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output tcphs_pkg::t_out_word o_out_word,
    input  logic                 i_out_stall
);
    import tcphs_pkg::*;

    logic [31:0] r_cl_addr, n_cl_addr;
    logic [31:0] r_sv_addr, n_sv_addr;
    logic [15:0] r_cl_port, n_cl_port;
    logic [15:0] r_sv_port, n_sv_port;
    // client and server sequence numbers (cs1, ss1) are kept already incremented by one
    logic [31:0] r_cs1, n_cs1;
    logic [31:0] r_ss1, n_ss1;
    logic [31:0] r_sack, n_sack;
    logic [31:0] r_fseq, n_fseq;
    logic [31:0] r_fack, n_fack;
    logic        r_conn, n_conn;
    logic        r_ov;
    t_out_word   r_out;
    t_out_word   n_out;
    logic        fwd_match;
    logic        rev_match;

    assign o_pop       = !i_q_stat.empty && (!r_ov || !i_out_stall);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    assign fwd_match = r_cl_addr == i_item.src_addr && r_sv_addr == i_item.dst_addr &&
                       r_cl_port == i_item.src_port && r_sv_port == i_item.dst_port;
    assign rev_match = r_cl_addr == i_item.dst_addr && r_sv_addr == i_item.src_addr &&
                       r_cl_port == i_item.dst_port && r_sv_port == i_item.src_port;

    always_comb begin
        n_cl_addr = r_cl_addr;
        n_sv_addr = r_sv_addr;
        n_cl_port = r_cl_port;
        n_sv_port = r_sv_port;
        n_cs1     = r_cs1;
        n_ss1     = r_ss1;
        n_sack    = r_sack;
        n_fseq    = r_fseq;
        n_fack    = r_fack;
        n_conn    = r_conn;
        n_out     = '0;

        if (i_item.syn_only) begin
            n_cs1     = i_item.seq_p1;
            n_cl_addr = i_item.src_addr;
            n_sv_addr = i_item.dst_addr;
            n_cl_port = i_item.src_port;
            n_sv_port = i_item.dst_port;
            n_conn    = 1'b0;
            n_out.syn_event = 1'b1;
        end

        if (i_item.synack) begin
            if (rev_match) begin
                n_sack = i_item.ack_number;
                n_ss1  = i_item.seq_p1;
                n_out.synack_event = 1'b1;
            end else begin
                n_sack = 32'd0;
                n_ss1  = 32'd1;
            end
        end

        if (i_item.ack_set) begin
            if (fwd_match) begin
                n_fseq = i_item.seq_number;
                n_fack = i_item.ack_number;
                n_out.ack_event = 1'b1;
            end else begin
                n_fseq = 32'd0;
                n_fack = 32'd0;
            end
        end

        // mark connected once all three relations line up
        if (n_sack == n_cs1 && n_fseq == n_cs1 && n_fack == n_ss1 && !n_conn) begin
            n_conn = 1'b1;
            n_out.connect_event = 1'b1;
        end

        n_out.is_connected    = n_conn;
        n_out.client_addr_out = n_cl_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_addr <= 32'd0;
            r_sv_addr <= 32'd0;
            r_cl_port <= 16'd0;
            r_sv_port <= 16'd0;
            r_cs1     <= 32'd1;
            r_ss1     <= 32'd1;
            r_sack    <= 32'd0;
            r_fseq    <= 32'd0;
            r_fack    <= 32'd0;
            r_conn    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cl_addr <= n_cl_addr;
                r_sv_addr <= n_sv_addr;
                r_cl_port <= n_cl_port;
                r_sv_port <= n_sv_port;
                r_cs1     <= n_cs1;
                r_ss1     <= n_ss1;
                r_sack    <= n_sack;
                r_fseq    <= n_fseq;
                r_fack    <= n_fack;
                r_conn    <= n_conn;
                r_ov      <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/tcp_handshake_tracker.sv @@
// A word accepted on the input passes the front register, the queue and the output register before o_out_valid.
// Throughput: one word per cycle while i_out_stall is low; the back stage updates the connection state on each pop.
// The front stage and the four-word queue absorb output stall without blocking input at once.
// Reset (synchronous, active low) clears the tuple, sequence state and connected mark,
// and empties the front register, queue and output register.
module tcp_handshake_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tcphs_pkg::t_in_word  i_in_word,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output tcphs_pkg::t_out_word o_out_word,
    input  logic                 i_out_stall
);
    import tcphs_pkg::*;

    t_q_stat   q_stat;
    logic      push;
    logic      pop;
    t_cls_word front_cls;
    t_cls_word q_item;

    tcphs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cls      (front_cls)
    );

    tcphs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_cls),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    tcphs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("queue push while full");

    a_conn_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.connect_event |-> o_out_word.is_connected)
        else $error("connect event without connected mark");

    a_syn_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.syn_event |->
            !o_out_word.ack_event && !o_out_word.synack_event)
        else $error("SYN event together with an ACK event");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the TCP handshake tracker: directed and random segments.
module tb_top;

    import tcphs_pkg::*;

    localparam int TargetWords = 600;
    localparam int CycleLimit  = 200000;

    // Tracks one connection's handshake and queues the report word due for each segment.
    class handshake_scoreboard;
        logic [31:0] cli_addr, srv_addr;
        logic [15:0] cli_port, srv_port;
        logic [31:0] cli_seq, srv_seq, srv_ack, fin_seq, fin_ack;
        logic        linked;
        t_out_word   due_reports[$];
        int          errors;

        function new();
            cli_addr = '0;
            srv_addr = '0;
            cli_port = '0;
            srv_port = '0;
            cli_seq  = '0;
            srv_seq  = '0;
            srv_ack  = '0;
            fin_seq  = '0;
            fin_ack  = '0;
            linked   = 1'b0;
            errors   = 0;
        endfunction

        function void note_segment(t_in_word w);
            t_out_word   r;
            logic        syn, ackf;
            logic [31:0] cs1, ss1;
            r    = '0;
            syn  = (w.tcp_flags & FlagSyn) != 8'h00;
            ackf = (w.tcp_flags & FlagAck) != 8'h00;
            if (syn && !ackf) begin
                cli_seq  = w.seq_number;
                cli_addr = w.src_addr;
                srv_addr = w.dst_addr;
                cli_port = w.src_port;
                srv_port = w.dst_port;
                linked   = 1'b0;
                r.syn_event = 1'b1;
            end
            if (syn && ackf) begin
                if (cli_addr == w.dst_addr && srv_addr == w.src_addr &&
                    cli_port == w.dst_port && srv_port == w.src_port) begin
                    srv_ack = w.ack_number;
                    srv_seq = w.seq_number;
                    r.synack_event = 1'b1;
                end else begin
                    srv_ack = '0;
                    srv_seq = '0;
                end
            end
            // a SYN+ACK also goes through the forward check
            if (ackf) begin
                if (cli_addr == w.src_addr && srv_addr == w.dst_addr &&
                    cli_port == w.src_port && srv_port == w.dst_port) begin
                    fin_seq = w.seq_number;
                    fin_ack = w.ack_number;
                    r.ack_event = 1'b1;
                end else begin
                    fin_seq = '0;
                    fin_ack = '0;
                end
            end
            cs1 = cli_seq + 32'd1;
            ss1 = srv_seq + 32'd1;
            if (srv_ack == cs1 && fin_seq == cs1 && fin_ack == ss1 && !linked) begin
                linked = 1'b1;
                r.connect_event = 1'b1;
            end
            r.is_connected    = linked;
            r.client_addr_out = cli_addr;
            due_reports.push_back(r);
        endfunction

        function void check_report(t_out_word got);
            t_out_word exp;
            if (due_reports.size() == 0) begin
                $error("report word with no segment pending: %h", got);
                errors++;
                return;
            end
            exp = due_reports.pop_front();
            if (got.syn_event !== exp.syn_event) begin
                $error("syn_event: expected %0d, got %0d", exp.syn_event, got.syn_event);
                errors++;
            end
            if (got.synack_event !== exp.synack_event) begin
                $error("synack_event: expected %0d, got %0d",
                       exp.synack_event, got.synack_event);
                errors++;
            end
            if (got.ack_event !== exp.ack_event) begin
                $error("ack_event: expected %0d, got %0d", exp.ack_event, got.ack_event);
                errors++;
            end
            if (got.connect_event !== exp.connect_event) begin
                $error("connect_event: expected %0d, got %0d",
                       exp.connect_event, got.connect_event);
                errors++;
            end
            if (got.is_connected !== exp.is_connected) begin
                $error("is_connected: expected %0d, got %0d",
                       exp.is_connected, got.is_connected);
                errors++;
            end
            if (got.client_addr_out !== exp.client_addr_out) begin
                $error("client_addr_out: expected %h, got %h",
                       exp.client_addr_out, got.client_addr_out);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    handshake_scoreboard sb = new();

    int n_sent         = 0;
    int cycle_count    = 0;
    int rx_hold_cycles = 0;
    bit calm           = 1'b0;

    tcp_handshake_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_word make_segment(logic [31:0] sa, logic [31:0] da,
                                              logic [15:0] sp, logic [15:0] dp,
                                              logic [31:0] seq, logic [31:0] ack,
                                              logic [7:0] fl);
        t_in_word w;
        w.src_addr   = sa;
        w.dst_addr   = da;
        w.src_port   = sp;
        w.dst_port   = dp;
        w.seq_number = seq;
        w.ack_number = ack;
        w.tcp_flags  = fl;
        return w;
    endfunction

    // flag bits other than SYN and ACK, present about half the time
    function automatic logic [7:0] stray_flags();
        logic [7:0] b;
        b = 8'($urandom);
        return $urandom_range(0, 1) ? (b & ~(FlagSyn | FlagAck)) : 8'h00;
    endfunction

    function automatic logic [31:0] pick_number();
        return ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    endfunction

    // Call at a clock edge; returns at the edge that accepts the word.
    task automatic send_segment(t_in_word w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_segment(w);
        n_sent++;
    endtask

    task automatic wait_for_reports();
        in_valid <= 1'b0;
        while (sb.due_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_noise();
        send_segment(make_segment($urandom, $urandom, 16'($urandom), 16'($urandom),
                                  $urandom, $urandom, 8'($urandom)));
    endtask

    // One handshake with random content; some steps are skipped or corrupted.
    task automatic run_handshake();
        logic [31:0] c_addr, s_addr, c_isn, s_isn, a2, s3, a3;
        logic [15:0] c_port, s_port;
        int          n_data;
        c_addr = $urandom;
        s_addr = ($urandom_range(0, 15) == 0) ? c_addr : 32'($urandom);
        c_port = 16'($urandom);
        s_port = ($urandom_range(0, 15) == 0) ? c_port : 16'($urandom);
        c_isn  = pick_number();
        s_isn  = pick_number();
        a2     = ($urandom_range(0, 7) == 0) ? 32'($urandom) : c_isn + 32'd1;
        s3     = ($urandom_range(0, 7) == 0) ? 32'($urandom) : c_isn + 32'd1;
        a3     = ($urandom_range(0, 7) == 0) ? 32'($urandom) : s_isn + 32'd1;
        if ($urandom_range(0, 9) != 0)
            send_segment(make_segment(c_addr, s_addr, c_port, s_port, c_isn, $urandom,
                                      FlagSyn | stray_flags()));
        if ($urandom_range(0, 5) == 0)
            send_noise();
        if ($urandom_range(0, 9) != 0)
            send_segment(make_segment(s_addr, c_addr, s_port, c_port, s_isn, a2,
                                      FlagSyn | FlagAck | stray_flags()));
        if ($urandom_range(0, 9) != 0)
            send_segment(make_segment(c_addr, s_addr, c_port, s_port, s3, a3,
                                      FlagAck | stray_flags()));
        n_data = $urandom_range(0, 3);
        repeat (n_data) begin
            if ($urandom_range(0, 2) == 0)
                send_segment(make_segment(s_addr, c_addr, s_port, c_port, $urandom,
                                          $urandom, FlagAck | stray_flags()));
            else
                send_segment(make_segment(c_addr, s_addr, c_port, s_port, s3, a3,
                                          8'($urandom) & ~FlagSyn));
        end
    endtask

    task automatic run_traffic(int upto);
        while (n_sent < upto) begin
            if ($urandom_range(0, 3) == 0)
                send_noise();
            else
                run_handshake();
        end
    endtask

    // Result side: random stalls, plus a long hold when requested.
    initial begin : report_sink
        int hold;
        wait (i_rst_n == 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 3);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_report(o_out_word);
        end
    end

    initial begin : segment_source
        logic [31:0] ca, sa, ci, si;
        ca = 32'h0A00_0001;
        sa = 32'hC0A8_0102;
        ci = 32'h1234_5678;
        si = 32'h8765_4321;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero, then an ACK that matches the cleared tuple
        send_segment(make_segment('0, '0, '0, '0, '0, '0, 8'h00));
        send_segment(make_segment('0, '0, '0, '0, 32'd1, 32'd1, FlagAck));
        send_segment(make_segment('1, '1, '1, '1, '1, '1, 8'hFF));
        // symmetric tuple of all ones: both direction checks match, numbers wrap
        send_segment(make_segment('1, '1, '1, '1, '1, '0, FlagSyn));
        send_segment(make_segment('1, '1, '1, '1, 32'hFFFF_FFFE, '0, FlagSyn | FlagAck));
        send_segment(make_segment('1, '1, '1, '1, '0, '1, FlagAck));
        send_segment(make_segment('1, '1, '1, '1, '0, '1, FlagAck));
        // SYN that clears the mark while the relations still hold: reconnects at once
        send_segment(make_segment('1, '1, '1, '1, '1, '0, FlagSyn | 8'h01));
        send_segment(make_segment($urandom, $urandom, 16'($urandom), 16'($urandom),
                                  $urandom, $urandom, 8'hED));
        // ordinary handshake with off-tuple segments mixed in
        send_segment(make_segment(ca, sa, 16'h8001, 16'h0050, ci, '0, FlagSyn | 8'h40));
        send_segment(make_segment(sa, ca, 16'h0051, 16'h8001, si, ci + 32'd1,
                                  FlagSyn | FlagAck));
        send_segment(make_segment(sa, ca, 16'h0050, 16'h8001, si, ci + 32'd1,
                                  FlagSyn | FlagAck));
        send_segment(make_segment(sa, sa, 16'h8001, 16'h0050, ci + 32'd1,
                                  si + 32'd1, FlagAck));
        send_segment(make_segment(ca, sa, 16'h8001, 16'h0050, ci + 32'd1,
                                  si + 32'd1, FlagAck | 8'h08));
        send_segment(make_segment(sa, ca, 16'h0050, 16'h8001, si + 32'd1,
                                  ci + 32'd1, FlagAck));
        send_segment(make_segment(ca, sa, 16'h8001, 16'h0050, ci + 32'd1,
                                  si + 32'd1, FlagAck | 8'h08));
        send_segment(make_segment(sa, ca, 16'h0050, 16'h8000, si, ci + 32'd1,
                                  8'hFF));
        send_segment(make_segment('0, '1, '0, '1, '0, '1, 8'hEF));
        send_segment(make_segment('0, '1, '0, '1, 32'd5, 32'd7, FlagAck));
        wait_for_reports();

        run_traffic(240);
        wait_for_reports();

        // long output hold while segments keep coming
        rx_hold_cycles = 80;
        run_traffic(340);

        calm = 1'b1;
        run_traffic(440);
        calm = 1'b0;
        wait_for_reports();

        rx_hold_cycles = 120;
        run_traffic(TargetWords);
        wait_for_reports();

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ tcp_handshake_tracker.f @@
design/tcphs_pkg.sv
design/tcphs_front.sv
design/tcphs_queue.sv
design/tcphs_back.sv
design/tcp_handshake_tracker.sv
sim/tb_top.sv
